// ===== hdl/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion with an explicit clock and active-low reset
`define ASSERT_CLK(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");

// clocked assertion on the block clock and reset
`define ASSERT_STD(label, prop) \
  `ASSERT_CLK(label, clk_i, rst_ni, prop)

`endif

// ===== hdl/brle_pkg.sv =====
// types and constants shared by the run-length encoder modules
package brle_pkg;

  localparam logic [7:0] RunPrefix    = 8'hC0;
  localparam logic [7:0] LiteralLimit = 8'd192;
  localparam logic [5:0] MaxRunReset  = 6'd63;
  localparam logic [5:0] MinRun       = 6'd2;

  // one closed run: count and byte value
  typedef struct packed {
    logic       valid;
    logic [5:0] count;
    logic [7:0] value;
  } run_rec_t;

  // runs closed by one input word, r0 always valid when the entry exists
  typedef struct packed {
    run_rec_t r0;
    run_rec_t r1;
  } run_entry_t;

  typedef enum logic {
    PhCount,
    PhValue
  } phase_e;

endpackage

// ===== hdl/brle_front.sv =====
// front end: accepts input words, tracks the current run and closes runs
module brle_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [5:0]           cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [7:0]           data_byte_i,
  input  logic                 last_in_i,
  input  logic                 full_i,
  output logic                 push_o,
  output brle_pkg::run_entry_t push_entry_o
);
  import brle_pkg::*;

  logic [5:0] max_run_q;
  logic [7:0] held_q, held_d, held_n;
  logic [5:0] count_q, count_d, count_n;
  logic       have_q, have_d;
  logic [5:0] limit;
  logic [5:0] count_inc;
  logic       accept;
  run_rec_t   rec_a, rec_b;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = full_i;
  assign accept      = in_valid_i && !full_i;
  assign limit       = (max_run_q < MinRun) ? MinRun : max_run_q;
  assign count_inc   = count_q + 6'd1;

  always_comb begin
    rec_a   = '0;
    rec_b   = '0;
    held_n  = held_q;
    count_n = count_q;
    if (have_q && (data_byte_i == held_q)) begin
      if (count_inc >= limit) begin
        rec_a   = '{valid: 1'b1, count: count_inc, value: held_q};
        count_n = '0;
      end else begin
        count_n = count_inc;
      end
    end else begin
      if (have_q && (count_q != '0)) begin
        rec_a = '{valid: 1'b1, count: count_q, value: held_q};
      end
      held_n  = data_byte_i;
      count_n = 6'd1;
    end
    // flush of the pending run at the end of a string
    if (last_in_i && (count_n != '0)) begin
      rec_b = '{valid: 1'b1, count: count_n, value: held_n};
    end

    held_d  = held_q;
    count_d = count_q;
    have_d  = have_q;
    if (accept) begin
      if (last_in_i) begin
        held_d  = '0;
        count_d = '0;
        have_d  = 1'b0;
      end else begin
        held_d  = held_n;
        count_d = count_n;
        have_d  = 1'b1;
      end
    end

    if (rec_a.valid) begin
      push_entry_o.r0 = rec_a;
      push_entry_o.r1 = rec_b;
    end else begin
      push_entry_o.r0 = rec_b;
      push_entry_o.r1 = '0;
    end
    push_o = accept && (rec_a.valid || rec_b.valid);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_run_q <= MaxRunReset;
      held_q    <= '0;
      count_q   <= '0;
      have_q    <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        max_run_q <= cfg_data_i;
      end
      held_q  <= held_d;
      count_q <= count_d;
      have_q  <= have_d;
    end
  end

endmodule

// ===== hdl/brle_queue.sv =====
// short queue of closed runs between front and back end
module brle_queue #(
  parameter int Depth = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  brle_pkg::run_entry_t push_entry_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output brle_pkg::run_entry_t head_o,
  output logic                 empty_o
);
  import brle_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  run_entry_t      entries_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ===== hdl/brle_back.sv =====
// back end: expands closed runs into literal or prefix and value words
module brle_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  brle_pkg::run_entry_t head_i,
  input  logic                 empty_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [7:0]           out_byte_o
);
  import brle_pkg::*;

  phase_e     phase_q, phase_d;
  logic       sel_q, sel_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic       load;
  logic       lit;
  logic       rec_done;
  run_rec_t   cur;

  assign load = !empty_i && (!out_valid_q || !out_stall_i);
  assign cur  = sel_q ? head_i.r1 : head_i.r0;
  assign lit  = (cur.count == 6'd1) && (cur.value < LiteralLimit);

  always_comb begin
    phase_d    = phase_q;
    sel_d      = sel_q;
    out_byte_d = out_byte_q;
    rec_done   = 1'b0;
    pop_o      = 1'b0;
    if (load) begin
      case (phase_q)
        PhCount: begin
          if (lit) begin
            out_byte_d = cur.value;
            rec_done   = 1'b1;
          end else begin
            out_byte_d = RunPrefix | {2'b00, cur.count};
            phase_d    = PhValue;
          end
        end
        PhValue: begin
          out_byte_d = cur.value;
          phase_d    = PhCount;
          rec_done   = 1'b1;
        end
        default: phase_d = PhCount;
      endcase
      if (rec_done) begin
        if (!sel_q && head_i.r1.valid) begin
          sel_d = 1'b1;
        end else begin
          sel_d = 1'b0;
          pop_o = 1'b1;
        end
      end
    end
    out_valid_d = load || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhCount;
      sel_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      sel_q       <= sel_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_byte_q <= out_byte_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;

endmodule

// ===== hdl/byte_run_length_encoder.sv =====
// run-length encoder top level: front end, run queue and output back end
//
// Input channel: in_valid_i with data_byte_i and last_in_i, stalled by in_stall_o.
// A word is taken at a clock edge with in_valid_i high and in_stall_o low.
// Output channel: out_valid_o with out_byte_o, stalled by out_stall_i.
// Config channel: cfg_valid_i / cfg_ready_o carries max_run in cfg_data_i;
// write it only while no encoded words are pending.
// The front end pushes the runs an input word closes (zero, one or two)
// into the queue together as one entry, in the cycle the word is taken.
// The back end sends one output word per cycle while out_stall_i is low,
// and one input produces up to 4 output words. The single-byte output port
// sets the sustained rate: one input per cycle for long runs, while
// alternating bytes of 192 or more give two output words per input.
// The first output word of an input passes through the queue entry and
// the output register before out_valid_o rises.
// While out_stall_i is high the output word holds; the queue keeps taking
// input until QueueDepth entries wait, then in_stall_o rises.
// Reset clears the held run, the queue and the output valid; max_run
// returns to 63.
module byte_run_length_encoder #(
  parameter int QueueDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [5:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       last_in_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o
);
  import brle_pkg::*;

  logic       push, full, pop, empty;
  run_entry_t push_entry, head;

  brle_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .data_byte_i  (data_byte_i),
    .last_in_i    (last_in_i),
    .full_i       (full),
    .push_o       (push),
    .push_entry_o (push_entry)
  );

  brle_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .full_o       (full),
    .pop_i        (pop),
    .head_o       (head),
    .empty_o      (empty)
  );

  brle_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o)
  );

endmodule

// ===== hdl/brle_checker.sv =====
// port-level checker for the run-length encoder and its bind
`include "assert_macros.svh"

module brle_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       cfg_valid_i,
  input logic       cfg_ready_o,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] out_byte_o
);

  logic seen_in_q;
  logic in_acc;

  assign in_acc = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_in_q <= 1'b0;
    end else if (in_acc) begin
      seen_in_q <= 1'b1;
    end
  end

  // a stalled output word holds
  `ASSERT_STD(out_hold_a, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o))
  // the queue only fills up right after an input word is taken
  `ASSERT_STD(stall_rise_a, $rose(in_stall_o) |-> $past(in_acc))
  // no output word appears before any input word was taken
  `ASSERT_STD(no_early_out_a, out_valid_o |-> seen_in_q)
  // the config port never refuses a write
  `ASSERT_STD(cfg_ready_a, cfg_valid_i |-> cfg_ready_o)

endmodule

bind byte_run_length_encoder brle_checker u_brle_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cfg_valid_i (cfg_valid_i),
  .cfg_ready_o (cfg_ready_o),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_byte_o  (out_byte_o)
);
